// ===== sv/rtq_pkg.sv =====
// shared types, constants and step functions for the rotation to quaternion pipeline
`default_nettype none
package rtq_pkg;

  localparam int ElemW    = 32;
  localparam int NumElems = 9;
  localparam int NumComps = 4;
  localparam int SqSteps  = 32;
  localparam int DivSteps = 31;
  localparam int MagW     = 31;
  localparam int QuoW     = 31;
  localparam int RemW     = 33;

  // one square root iteration: remainder and partial root
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] res;
  } sqrt_t;

  // sideband that travels with the divider lanes
  typedef struct packed {
    logic                deg;
    logic [NumComps-1:0] neg;
  } div_side_t;

  typedef logic [NumComps-1:0][MagW-1:0] mag_vec_t;
  typedef logic [NumComps-1:0][QuoW-1:0] quo_vec_t;

  // restoring square root step for one result bit
  function automatic sqrt_t sqrt_step(input sqrt_t cur, input logic [63:0] bitv);
    sqrt_t       nx;
    logic [63:0] trial;
    trial = cur.res + bitv;
    if (cur.rem >= trial) begin
      nx.rem = cur.rem - trial;
      nx.res = (cur.res >> 1) + bitv;
    end else begin
      nx.rem = cur.rem;
      nx.res = cur.res >> 1;
    end
    return nx;
  endfunction

  // right shift that brings every magnitude below 2^31
  function automatic logic [5:0] norm_shift(input logic [63:0] w);
    logic [5:0] s;
    s = '0;
    for (int i = 31; i < 64; i++) begin
      if (w[i]) s = 6'(i - 30);
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== sv/rtq_div.sv =====
// four-lane pipelined restoring divider, one quotient bit per stage
`default_nettype none
module rtq_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire rtq_pkg::div_side_t in_side,
  input  wire rtq_pkg::mag_vec_t  in_mag,
  input  wire logic [31:0]        in_den,
  output logic                    out_valid,
  output rtq_pkg::div_side_t      out_side,
  output rtq_pkg::quo_vec_t       out_quo
);
  import rtq_pkg::*;

  logic                                  vld  [DivSteps];
  div_side_t                             side [DivSteps];
  logic [31:0]                           den  [DivSteps];
  logic [NumComps-1:0][RemW-1:0]         rem  [DivSteps];
  logic [NumComps-1:0][QuoW-1:0]         quo  [DivSteps];

  for (genvar j = 0; j < DivSteps; j++) begin : g_stage
    logic [NumComps-1:0][RemW-1:0] rem_next;
    logic [NumComps-1:0][QuoW-1:0] quo_next;
    logic [NumComps-1:0][RemW-1:0] rin;
    logic [NumComps-1:0][QuoW-1:0] quo_in;
    logic                          vld_in;
    div_side_t                     side_in;
    logic [31:0]                   den_in;

    // first stage takes the dividend, later stages the shifted remainder
    if (j == 0) begin : g_first
      assign vld_in  = in_valid;
      assign side_in = in_side;
      assign den_in  = in_den;
      assign quo_in  = '0;
      always_comb begin
        for (int k = 0; k < NumComps; k++) rin[k] = {2'b00, in_mag[k]};
      end
    end else begin : g_next
      assign vld_in  = vld[j-1];
      assign side_in = side[j-1];
      assign den_in  = den[j-1];
      assign quo_in  = quo[j-1];
      always_comb begin
        for (int k = 0; k < NumComps; k++) rin[k] = {rem[j-1][k][RemW-2:0], 1'b0};
      end
    end

    // one compare and subtract per lane
    always_comb begin
      logic ge;
      for (int k = 0; k < NumComps; k++) begin
        ge = (rin[k] >= {1'b0, den_in});
        rem_next[k] = ge ? (rin[k] - {1'b0, den_in}) : rin[k];
        quo_next[k] = {quo_in[k][QuoW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[j] <= side_in;
        den[j]  <= den_in;
        rem[j]  <= rem_next;
        quo[j]  <= quo_next;
      end
    end
  end

  assign out_valid = vld[DivSteps-1];
  assign out_side  = side[DivSteps-1];
  assign out_quo   = quo[DivSteps-1];

endmodule
`default_nettype wire

// ===== sv/rotation_to_quaternion.sv =====
// top level: rotation matrix to unit quaternion, fully pipelined
`default_nettype none
// Converts one signed Q2.30 rotation matrix per transaction into a unit
// quaternion (qx, qy, qz, qw) in Q2.30 with qw never negative and the
// transposed sign convention. One matrix can be taken every cycle while the
// output is not stalled. Most of the pipeline is two 32-stage square root
// pipelines (pivot and norm) and a 31-stage divider, one result bit per
// stage. A stall on the output freezes the whole pipeline. When the
// pivot or the norm is zero the quaternion is all zero and tuser is 1.
module rotation_to_quaternion (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
  input  wire logic [287:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // qx, qy, qz, qw from bit 0 up
  output logic [127:0]      m_tdata,
  // degenerate
  output logic [0:0]        m_tuser
);
  import rtq_pkg::*;

  typedef struct packed {
    logic [1:0]                piv;
    logic [NumComps-1:0][32:0] nmag;
    logic [NumComps-1:0]       nneg;
  } side1_t;

  typedef struct packed {
    mag_vec_t  mag;
    div_side_t ctl;
  } side2_t;

  logic en;

  // whole pipeline advances unless the output is held
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // pivot choice and radicand
  logic signed [35:0]        e [NumElems];
  logic [1:0]                piv_c;
  logic [32:0]               rc_c;
  logic [NumComps-1:0][32:0] nmag_c;
  logic [NumComps-1:0]       nneg_c;

  for (genvar k = 0; k < NumElems; k++) begin : g_ext
    assign e[k] = 36'(signed'(s_tdata[k*ElemW +: ElemW]));
  end

  always_comb begin
    logic signed [35:0] t;
    logic signed [35:0] r;
    logic signed [35:0] n [NumComps];
    t = e[0] + e[4] + e[8];
    for (int k = 0; k < NumComps; k++) n[k] = '0;
    priority if (e[0] >= t && e[0] >= e[4] && e[0] >= e[8]) begin
      piv_c = 2'd0;
      r     = 36'sd1073741824 + 2 * e[0] - t;
      n[1]  = e[1] + e[3];
      n[2]  = e[2] + e[6];
      n[3]  = e[5] - e[7];
    end else if (e[4] >= t && e[4] >= e[0] && e[4] >= e[8]) begin
      piv_c = 2'd1;
      r     = 36'sd1073741824 + 2 * e[4] - t;
      n[0]  = e[1] + e[3];
      n[2]  = e[5] + e[7];
      n[3]  = e[6] - e[2];
    end else if (e[8] >= t && e[8] >= e[0] && e[8] >= e[4]) begin
      piv_c = 2'd2;
      r     = 36'sd1073741824 + 2 * e[8] - t;
      n[0]  = e[2] + e[6];
      n[1]  = e[5] + e[7];
      n[3]  = e[1] - e[3];
    end else begin
      piv_c = 2'd3;
      r     = 36'sd1073741824 + t;
      n[0]  = e[5] - e[7];
      n[1]  = e[6] - e[2];
      n[2]  = e[1] - e[3];
    end
    rc_c = r[35] ? '0 : r[32:0];
    for (int k = 0; k < NumComps; k++) begin
      nneg_c[k] = n[k][35];
      nmag_c[k] = n[k][35] ? 33'(-n[k]) : 33'(n[k]);
    end
  end

  // pivot square root pipeline
  logic   v1  [SqSteps+1];
  sqrt_t  sq1 [SqSteps+1];
  side1_t sd1 [SqSteps+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1[0] <= 1'b0;
    end else if (en) begin
      v1[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq1[0].rem    <= {3'b000, rc_c, 28'd0};
      sq1[0].res    <= '0;
      sd1[0].piv    <= piv_c;
      sd1[0].nmag   <= nmag_c;
      sd1[0].nneg   <= nneg_c;
    end
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sq1
    localparam int Sh = 2 * (SqSteps - 1 - k);
    always_ff @(posedge clk) begin
      if (rst) begin
        v1[k+1] <= 1'b0;
      end else if (en) begin
        v1[k+1] <= v1[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq1[k+1] <= sqrt_step(sq1[k], 64'd1 << Sh);
        sd1[k+1] <= sd1[k];
      end
    end
  end

  // proportional vector and sign fold
  logic [31:0]               p_c;
  logic [63:0]               pp_c;
  logic [NumComps-1:0][63:0] magp_c;
  logic [NumComps-1:0]       negp_c;

  assign p_c  = sq1[SqSteps].res[31:0];
  assign pp_c = p_c * p_c;

  always_comb begin
    for (int k = 0; k < NumComps; k++) begin
      if (sd1[SqSteps].piv == 2'(k)) begin
        magp_c[k] = pp_c;
        negp_c[k] = 1'b0;
      end else begin
        magp_c[k] = {3'b000, sd1[SqSteps].nmag[k], 28'd0};
        negp_c[k] = sd1[SqSteps].nneg[k];
      end
    end
    if (negp_c[3]) negp_c = ~negp_c;
  end

  logic                      vp, vo, vl, vh, vm;
  logic [NumComps-1:0][63:0] magp, mago, magl;
  logic [NumComps-1:0]       negp, nego, negl, negh, negm;
  logic                      degp, dego, degl, degh, degm;
  logic [63:0]               orw;
  logic [5:0]                shl;
  mag_vec_t                  magh, magm;
  logic [NumComps-1:0][61:0] sqm;

  // valid bits of the scaling stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
      vo <= 1'b0;
      vl <= 1'b0;
      vh <= 1'b0;
      vm <= 1'b0;
    end else if (en) begin
      vp <= v1[SqSteps];
      vo <= vp;
      vl <= vo;
      vh <= vl;
      vm <= vh;
    end
  end

  // scale and square
  always_ff @(posedge clk) begin
    if (en) begin
      magp <= magp_c;
      negp <= negp_c;
      degp <= (p_c == '0);
      mago <= magp;
      nego <= negp;
      dego <= degp;
      orw  <= magp[0] | magp[1] | magp[2] | magp[3];
      magl <= mago;
      negl <= nego;
      degl <= dego;
      shl  <= norm_shift(orw);
      for (int k = 0; k < NumComps; k++) magh[k] <= MagW'(magl[k] >> shl);
      negh <= negl;
      degh <= degl;
      for (int k = 0; k < NumComps; k++) sqm[k] <= magh[k] * magh[k];
      magm <= magh;
      negm <= negh;
      degm <= degh;
    end
  end

  // norm square root pipeline
  logic   v2  [SqSteps+1];
  sqrt_t  sq2 [SqSteps+1];
  side2_t sd2 [SqSteps+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2[0] <= 1'b0;
    end else if (en) begin
      v2[0] <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq2[0].rem     <= 64'(sqm[0]) + 64'(sqm[1]) + 64'(sqm[2]) + 64'(sqm[3]);
      sq2[0].res     <= '0;
      sd2[0].mag     <= magm;
      sd2[0].ctl.neg <= negm;
      sd2[0].ctl.deg <= degm;
    end
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sq2
    localparam int Sh = 2 * (SqSteps - 1 - k);
    always_ff @(posedge clk) begin
      if (rst) begin
        v2[k+1] <= 1'b0;
      end else if (en) begin
        v2[k+1] <= v2[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq2[k+1] <= sqrt_step(sq2[k], 64'd1 << Sh);
        sd2[k+1] <= sd2[k];
      end
    end
  end

  // division by the norm
  logic [31:0] nrm;
  div_side_t   div_ctl;
  logic        dv_valid;
  div_side_t   dv_side;
  quo_vec_t    dv_quo;

  assign nrm         = sq2[SqSteps].res[31:0];
  assign div_ctl.neg = sd2[SqSteps].ctl.neg;
  assign div_ctl.deg = sd2[SqSteps].ctl.deg || (nrm == '0);

  rtq_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2[SqSteps]),
    .in_side   (div_ctl),
    .in_mag    (sd2[SqSteps].mag),
    .in_den    (nrm),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_quo   (dv_quo)
  );

  // output register with sign applied
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NumComps; k++) begin
        if (dv_side.deg)        m_tdata[k*32 +: 32] <= '0;
        else if (dv_side.neg[k]) m_tdata[k*32 +: 32] <= -{1'b0, dv_quo[k]};
        else                    m_tdata[k*32 +: 32] <= {1'b0, dv_quo[k]};
      end
      m_tuser <= dv_side.deg;
    end
  end

endmodule
`default_nettype wire
